// ----- design/athc_pkg.sv -----
// shared types, constants and helpers of the adaptive threshold hit counter
package athc_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 50;
  localparam int unsigned MAG_W = 12;
  localparam int unsigned LEVEL_W = 17;
  localparam int unsigned TOTAL_W = 20;
  localparam int unsigned SQTOT_W = 32;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 17'h1FFFF;
  localparam logic [MAG_W-1:0] MAG_MAX = 12'hFFF;

  localparam logic [8:0] SENS_RESET = 9'd64;
  localparam logic [15:0] GAP_RESET = 16'd250;
  localparam logic [3:0] PEAKS_RESET = 4'd4;
  localparam logic signed [11:0] XB_RESET = 12'sd0;
  localparam logic signed [11:0] YB_RESET = 12'sd0;
  localparam logic signed [11:0] ZB_RESET = -12'sd512;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SENS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YB = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZB = 3'd5;

  typedef struct packed {
    logic [31:0] time_ms;
    logic signed [11:0] x_raw;
    logic signed [11:0] y_raw;
    logic signed [11:0] z_raw;
  } sample_t;

  typedef struct packed {
    logic [11:0] magnitude;
    logic [16:0] level;
    logic armed;
    logic peak_start;
    logic hit_now;
    logic [31:0] hits_total;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQUARE, ST_MAG, ST_MAG_WAIT, ST_JUDGE, ST_RD_WAIT, ST_UPDATE,
    ST_DIV, ST_VAR, ST_SD, ST_SD_WAIT, ST_LVL, ST_OUT
  } state_t;

  // request to the shared iterative units
  typedef struct packed {
    logic start;
    logic [31:0] operand;
  } unit_req_t;

endpackage

// ----- design/athc_isqrt.sv -----
// iterative 32-bit integer square root, two bits per cycle
module athc_isqrt (
  input  logic clk,
  input  logic rst,
  input  athc_pkg::unit_req_t req,
  output logic busy,
  output logic done,
  output logic [15:0] root
);
  import athc_pkg::*;

  logic [31:0] rem;
  logic [31:0] acc;
  logic [31:0] bitv;
  logic [31:0] trial;

  assign trial = acc + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem <= req.operand;
        acc <= '0;
        bitv <= 32'h4000_0000;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + bitv;
        end else begin
          acc <= acc >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 32'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = acc[15:0];
endmodule

// ----- design/athc_div.sv -----
// unsigned divide of a 32-bit value by the window size, reciprocal multiply and one correction
module athc_div #(
  parameter int unsigned WINDOW_SIZE = athc_pkg::WINDOW_SIZE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  athc_pkg::unit_req_t req,
  output logic busy,
  output logic done,
  output logic [31:0] quot
);
  import athc_pkg::*;

  localparam logic [8:0] DIVISOR = 9'(WINDOW_SIZE);
  // floor(2^32 / size), so the estimate is the quotient or one below it
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(WINDOW_SIZE));

  logic [31:0] num;
  logic [31:0] est;
  logic step;
  logic [31:0] est_next;
  logic [31:0] rem_v;

  assign est_next = 32'((64'(num) * 64'(RECIP)) >> 32);
  assign rem_v = num - est * 32'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 1'b0;
        num <= req.operand;
      end else if (busy) begin
        if (!step) begin
          est <= est_next;
          step <= 1'b1;
        end else begin
          quot <= (rem_v >= 32'(DIVISOR)) ? est + 32'd1 : est;
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- design/athc_window_mem.sv -----
// magnitude window memory, one write and one registered read per cycle
module athc_window_mem #(
  parameter int unsigned WINDOW_SIZE = athc_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned AW = $clog2(WINDOW_SIZE)
) (
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  logic [athc_pkg::MAG_W-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [athc_pkg::MAG_W-1:0] rdata
);
  import athc_pkg::*;

  logic [MAG_W-1:0] mem [WINDOW_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/adaptive_threshold_hit_counter.sv -----
// top level of the adaptive threshold hit counter
// Accepts one accelerometer sample at a time and returns one result per
// sample. A sample that leaves the level alone passes from the input
// transfer to the result through squaring, the magnitude square root with
// its start, judging, the window read, the update and the output register.
// When the level is refreshed, two divides by the window size (reciprocal
// multiply plus one correction each), the variance and a second square root
// with the level step are added. The window of magnitudes lives in a
// synchronous memory whose registered read is waited for in ST_RD_WAIT,
// ahead of the update. The first WINDOW_SIZE samples only fill the window
// and report armed low; afterwards the level is mean + sensitivity_q4/16 *
// stddev, refreshed only while the signal stays at or below the level. A
// finished result sits in an output register, so the next sample may be
// accepted once the block is idle, unless that result is held by out_stall.
// Configuration writes are taken every cycle and must only happen while the
// block is idle.
module adaptive_threshold_hit_counter #(
  parameter int unsigned WINDOW_SIZE = athc_pkg::WINDOW_SIZE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  athc_pkg::sample_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output athc_pkg::result_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [athc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import athc_pkg::*;

  localparam int unsigned AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_SIZE - 1);

  // configuration registers
  logic [8:0] sens;
  logic [15:0] gap;
  logic [3:0] peaks;
  logic signed [11:0] xb, yb, zb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens <= SENS_RESET;
      gap <= GAP_RESET;
      peaks <= PEAKS_RESET;
      xb <= XB_RESET;
      yb <= YB_RESET;
      zb <= ZB_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SENS: sens <= cfg_data[8:0];
        REG_GAP: gap <= cfg_data[15:0];
        REG_PEAKS: peaks <= cfg_data[3:0];
        REG_XB: xb <= cfg_data[11:0];
        REG_YB: yb <= cfg_data[11:0];
        REG_ZB: zb <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // block state
  state_t state, state_next;
  sample_t smp;
  logic [AW-1:0] write_pos;
  logic filling;
  logic [TOTAL_W-1:0] window_total;
  logic [SQTOT_W-1:0] window_square_total;
  logic [LEVEL_W-1:0] current_level;
  logic above_level;
  logic [3:0] train_peaks;
  logic in_train;
  logic [31:0] last_peak_time;
  logic [31:0] hit_total;

  // per-item work registers
  logic [31:0] work;
  logic [MAG_W-1:0] mag;
  logic [31:0] mean;
  logic [31:0] msq;
  logic div_second;
  logic [LEVEL_W-1:0] lvl_used;
  logic armed_r, pstart_r, hit_r;
  logic [12:0] dx, dy, dz;

  // shared units
  unit_req_t sq_req, dv_req;
  logic sq_busy, sq_done, dv_busy, dv_done;
  logic [15:0] sq_root;
  logic [31:0] dv_quot;

  athc_isqrt u_sqrt (
    .clk(clk), .rst(rst), .req(sq_req),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  athc_div #(.WINDOW_SIZE(WINDOW_SIZE)) u_div (
    .clk(clk), .rst(rst), .req(dv_req),
    .busy(dv_busy), .done(dv_done), .quot(dv_quot)
  );

  // window memory
  logic mem_we;
  logic [MAG_W-1:0] old_mag;

  athc_window_mem #(.WINDOW_SIZE(WINDOW_SIZE), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(write_pos), .wdata(mag),
    .raddr(write_pos), .rdata(old_mag)
  );

  logic in_xfer, out_xfer;
  assign in_xfer = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);

  // baseline-corrected axes, 13 bit signed
  assign dx = 13'($signed(smp.x_raw)) - 13'($signed(xb));
  assign dy = 13'($signed(smp.y_raw)) - 13'($signed(yb));
  assign dz = 13'($signed(smp.z_raw)) - 13'($signed(zb));

  // squares, one axis at a time in ST_SQUARE via a small counter
  logic [1:0] axis;
  logic signed [12:0] cur_axis;
  logic [25:0] cur_sq;
  always_comb begin
    unique case (axis)
      2'd0: cur_axis = dx;
      2'd1: cur_axis = dy;
      default: cur_axis = dz;
    endcase
  end
  assign cur_sq = 26'($signed(cur_axis) * $signed(cur_axis));

  // judging terms
  logic over;
  logic [3:0] p_eff;
  logic [4:0] next_peaks;
  logic [31:0] elapsed;
  assign over = {5'd0, mag} > current_level;
  assign p_eff = (peaks == 4'd0) ? 4'd1 : peaks;
  assign next_peaks = {1'b0, train_peaks} + 5'd1;
  assign elapsed = smp.time_ms - last_peak_time;

  // level terms
  logic [31:0] m2;
  logic [31:0] var_v;
  logic [24:0] sens_sd;
  logic [24:0] lvl_sum;
  assign m2 = mean * mean;
  assign var_v = (msq > m2) ? (msq - m2) : 32'd0;
  assign sens_sd = 25'(sens * sq_root[11:0]);
  assign lvl_sum = {8'd0, mean[16:0]} + {4'd0, sens_sd[24:4]};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_SQUARE;
      ST_SQUARE: if (axis == 2'd2) state_next = ST_MAG;
      ST_MAG: state_next = ST_MAG_WAIT;
      ST_MAG_WAIT: if (sq_done) state_next = ST_JUDGE;
      ST_JUDGE: state_next = ST_RD_WAIT;
      ST_RD_WAIT: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (!filling && over) state_next = ST_OUT;
        else if (filling && write_pos != LAST_POS) state_next = ST_OUT;
        else state_next = ST_DIV;
      end
      ST_DIV: if (dv_done && div_second) state_next = ST_VAR;
      ST_VAR: state_next = ST_SD;
      ST_SD: state_next = ST_SD_WAIT;
      ST_SD_WAIT: if (sq_done) state_next = ST_LVL;
      ST_LVL: state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sq_req = '0;
    dv_req = '0;
    mem_we = 1'b0;
    unique case (state)
      ST_MAG: begin
        sq_req.start = 1'b1;
        sq_req.operand = work;
      end
      ST_UPDATE: begin
        mem_we = filling || !over;
        dv_req.start = !(filling && write_pos != LAST_POS) && (filling || !over);
        // during the fill nothing leaves the window
        dv_req.operand = 32'(window_total) - (filling ? 32'd0 : 32'(old_mag)) + 32'(mag);
      end
      ST_DIV: if (dv_done && !div_second) begin
        dv_req.start = 1'b1;
        dv_req.operand = window_square_total;
      end
      ST_SD: begin
        sq_req.start = 1'b1;
        sq_req.operand = var_v;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      write_pos <= '0;
      filling <= 1'b1;
      window_total <= '0;
      window_square_total <= '0;
      current_level <= '0;
      above_level <= 1'b0;
      train_peaks <= '0;
      in_train <= 1'b0;
      last_peak_time <= '0;
      hit_total <= '0;
    end else begin
      state <= state_next;
      if (out_xfer) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_xfer) begin
          smp <= in_data;
          work <= '0;
          axis <= 2'd0;
        end
        ST_SQUARE: begin
          work <= work + 32'(cur_sq);
          axis <= axis + 2'd1;
        end
        ST_MAG_WAIT: if (sq_done) begin
          mag <= (sq_root > 16'(MAG_MAX)) ? MAG_MAX : sq_root[11:0];
        end
        ST_JUDGE: begin
          lvl_used <= filling ? '0 : current_level;
          armed_r <= !filling;
          pstart_r <= 1'b0;
          hit_r <= 1'b0;
          div_second <= 1'b0;
          if (!filling) begin
            if (!above_level && over) begin
              pstart_r <= 1'b1;
              last_peak_time <= smp.time_ms;
              if (next_peaks >= {1'b0, p_eff}) begin
                hit_r <= 1'b1;
                hit_total <= hit_total + 32'd1;
                train_peaks <= '0;
                in_train <= 1'b0;
              end else begin
                train_peaks <= next_peaks[3:0];
                in_train <= 1'b1;
              end
            end else if (in_train && elapsed > {16'd0, gap}) begin
              hit_r <= 1'b1;
              hit_total <= hit_total + 32'd1;
              in_train <= 1'b0;
              train_peaks <= '0;
            end
            above_level <= over;
          end
        end
        ST_UPDATE: begin
          if (filling || !over) begin
            window_total <= dv_req.operand[TOTAL_W-1:0];
            window_square_total <= window_square_total
              - (filling ? 32'd0 : 32'(old_mag) * 32'(old_mag))
              + 32'(mag) * 32'(mag);
            write_pos <= (write_pos == LAST_POS) ? '0 : write_pos + AW'(1);
            if (filling && write_pos == LAST_POS) filling <= 1'b0;
          end
        end
        ST_DIV: if (dv_done) begin
          if (!div_second) begin
            mean <= dv_quot;
            div_second <= 1'b1;
          end else begin
            msq <= dv_quot;
          end
        end
        ST_LVL: begin
          current_level <= (lvl_sum > 25'(LEVEL_MAX)) ? LEVEL_MAX : lvl_sum[16:0];
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          out_data.magnitude <= mag;
          out_data.level <= lvl_used;
          out_data.armed <= armed_r;
          out_data.peak_start <= pstart_r;
          out_data.hit_now <= hit_r;
          out_data.hits_total <= hit_total;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> state == ST_IDLE) else $error("input transfer while busy");
  a_armed_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.armed) |-> (out_data.level == '0 && !out_data.hit_now))
    else $error("unarmed result carries a judgement");
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_JUDGE && !hit_r) |=> (hit_total == $past(hit_total) + 32'(hit_r)))
    else $error("hit count out of step");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    write_pos <= LAST_POS) else $error("window position out of range");
  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> (!sq_busy && !dv_busy)) else $error("unit busy while idle");
`endif
endmodule

// ----- verif/tb.sv -----
// testbench of the adaptive threshold hit counter with its own result predictor
`timescale 1ns / 100ps

module tb;
  import athc_pkg::*;

  localparam int unsigned WIN = WINDOW_SIZE_DEF;
  localparam int unsigned ITEMS_TOTAL = 800;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  sample_t in_data;
  logic out_valid;
  logic out_stall;
  result_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  adaptive_threshold_hit_counter u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // register copies kept by the predictor
  logic [8:0] sens_q4;
  logic [15:0] gap_ms;
  logic [3:0] peaks_needed;
  logic signed [11:0] base_x, base_y, base_z;

  // window and detector state kept by the predictor
  logic [11:0] mag_window [WIN];
  int unsigned win_pos;
  bit win_filling;
  logic [31:0] win_sum, win_sq_sum;
  logic [16:0] thresh;
  bit over_thresh;
  int unsigned peak_count;
  bit train_open;
  logic [31:0] last_peak_ms;
  logic [31:0] hit_count;

  result_t expected_results[$];
  int unsigned error_count;
  int unsigned results_seen;
  int unsigned sent_count;
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned stall_hold;
  bit pressure_done;
  int unsigned cycle_count;
  logic [31:0] now_ms;

  typedef struct {
    sample_t s;
    bit typed;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic logic [31:0] floor_sqrt(logic [31:0] n);
    logic [31:0] root, b;
    root = 0;
    b = 32'h4000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic void recompute_threshold();
    logic [31:0] mean, msq, m2, var_v, sd, lvl;
    mean = win_sum / WIN;
    msq = win_sq_sum / WIN;
    m2 = mean * mean;
    var_v = (msq > m2) ? msq - m2 : 32'd0;
    sd = floor_sqrt(var_v);
    lvl = mean + ((32'(sens_q4) * sd) >> 4);
    thresh = (lvl > 32'(LEVEL_MAX)) ? LEVEL_MAX : lvl[16:0];
  endfunction

  function automatic void model_reset();
    sens_q4 = SENS_RESET; gap_ms = GAP_RESET; peaks_needed = PEAKS_RESET;
    base_x = XB_RESET; base_y = YB_RESET; base_z = ZB_RESET;
    foreach (mag_window[i]) mag_window[i] = '0;
    win_pos = 0; win_filling = 1;
    win_sum = 0; win_sq_sum = 0;
    thresh = 0; over_thresh = 0;
    peak_count = 0; train_open = 0;
    last_peak_ms = 0; hit_count = 0;
  endfunction

  // works out the result of one accepted sample and advances the detector
  function automatic result_t detect_sample(sample_t s);
    result_t r;
    int dx, dy, dz;
    logic [31:0] sq, mag, old, need;
    int unsigned nxt;
    bit armed_now, over, pstart, hit;
    dx = int'(s.x_raw) - int'(base_x);
    dy = int'(s.y_raw) - int'(base_y);
    dz = int'(s.z_raw) - int'(base_z);
    sq = 32'(dx * dx) + 32'(dy * dy) + 32'(dz * dz);
    mag = floor_sqrt(sq);
    if (mag > 32'(MAG_MAX)) mag = 32'(MAG_MAX);
    r.level = thresh;
    armed_now = !win_filling;
    pstart = 0;
    hit = 0;
    need = (peaks_needed == 0) ? 32'd1 : 32'(peaks_needed);
    if (armed_now) begin
      over = mag > 32'(thresh);
      if (!over_thresh && over) begin
        // rising crossing starts a peak
        nxt = peak_count + 1;
        pstart = 1;
        if (nxt >= need) begin
          nxt = 0;
          hit = 1;
        end
        peak_count = nxt;
        train_open = nxt > 0;
        last_peak_ms = s.time_ms;
      end else if (train_open && (s.time_ms - last_peak_ms) > 32'(gap_ms)) begin
        // quiet gap closes a partial train
        hit = 1;
        train_open = 0;
        peak_count = 0;
      end
      over_thresh = over;
      if (hit) hit_count = hit_count + 1;
      if (!over_thresh) begin
        old = 32'(mag_window[win_pos]);
        win_sum = win_sum - old + mag;
        win_sq_sum = win_sq_sum - old * old + mag * mag;
        mag_window[win_pos] = mag[11:0];
        recompute_threshold();
        win_pos = (win_pos + 1 >= WIN) ? 0 : win_pos + 1;
      end
    end else begin
      mag_window[win_pos] = mag[11:0];
      win_sum = win_sum + mag;
      win_sq_sum = win_sq_sum + mag * mag;
      win_pos = (win_pos + 1 >= WIN) ? 0 : win_pos + 1;
      if (win_pos == 0) begin
        win_filling = 0;
        recompute_threshold();
      end
    end
    r.magnitude = mag[11:0];
    r.armed = armed_now;
    r.peak_start = pstart;
    r.hit_now = hit;
    r.hits_total = hit_count;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             results_seen, field, got, want);
    error_count++;
  endtask

  // one sample transfer, with a random idle stretch ahead of it
  task automatic send_sample(sample_t s, bit typed);
    result_t exp_r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_r = detect_sample(s);
    // rows read off at a glance: at-rest samples during the fill report all zero
    if (typed) exp_r = '0;
    expected_results.push_back(exp_r);
    sent_count++;
    if (sent_count * 3 >= ITEMS_TOTAL * 2) begin
      send_idle_pct = 0; recv_stall_pct = 0;
    end else if (sent_count * 3 >= ITEMS_TOTAL) begin
      send_idle_pct = 47; recv_stall_pct = 19;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SENS: sens_q4 = val[8:0];
      REG_GAP: gap_ms = val[15:0];
      REG_PEAKS: peaks_needed = val[3:0];
      REG_XB: base_x = val[11:0];
      REG_YB: base_y = val[11:0];
      REG_ZB: base_z = val[11:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [11:0] clamp12(int v);
    if (v > 2047) return 12'sd2047;
    if (v < -2048) return -12'sd2048;
    return 12'(v);
  endfunction

  // mostly quiet samples around the baseline with spikes, some pure noise
  function automatic sample_t make_sample(int unsigned span);
    sample_t s;
    int noise, off;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) now_ms = now_ms + span + $urandom_range(100);
    else now_ms = now_ms + $urandom_range(1, 6);
    s.time_ms = now_ms;
    if (pick >= 88) begin
      s.x_raw = 12'($urandom);
      s.y_raw = 12'($urandom);
      s.z_raw = 12'($urandom);
      if (pick >= 96) s.time_ms = $urandom;
      return s;
    end
    noise = ($urandom_range(9) == 0) ? 40 : 6;
    s.x_raw = clamp12(int'(base_x) + $urandom_range(2 * noise) - noise);
    s.y_raw = clamp12(int'(base_y) + $urandom_range(2 * noise) - noise);
    s.z_raw = clamp12(int'(base_z) + $urandom_range(2 * noise) - noise);
    if (pick < 30) begin
      off = $urandom_range(300, 2500);
      s.x_raw = clamp12(int'(base_x) + ((base_x >= 0) ? -off : off));
    end
    return s;
  endfunction

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    results_seen = 0;
    sent_count = 0;
    send_idle_pct = 19;
    recv_stall_pct = 47;
    stall_hold = 0;
    pressure_done = 0;
    now_ms = 0;
    model_reset();
  end

  // results side: check each transfer, stall at random, one long hold-off
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result transfer: 0x%0h", out_data);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.magnitude != want.magnitude)
            report_mismatch("magnitude", out_data.magnitude, want.magnitude);
          if (out_data.level != want.level)
            report_mismatch("level", out_data.level, want.level);
          if (out_data.armed != want.armed)
            report_mismatch("armed", out_data.armed, want.armed);
          if (out_data.peak_start != want.peak_start)
            report_mismatch("peak_start", out_data.peak_start, want.peak_start);
          if (out_data.hit_now != want.hit_now)
            report_mismatch("hit_now", out_data.hit_now, want.hit_now);
          if (out_data.hits_total != want.hits_total)
            report_mismatch("hits_total", out_data.hits_total, want.hits_total);
        end
        results_seen++;
      end
      if (stall_hold != 0) begin
        stall_hold--;
        out_stall <= 1'b1;
      end else if (!pressure_done && results_seen == 120) begin
        // long hold-off while samples keep coming, so the input backs up
        pressure_done = 1;
        stall_hold = 400;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("adaptive_threshold_hit_counter test failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    // register settings per phase: sensitivity, gap, peaks, x, y, z baselines
    int settings [5][6] = '{
      '{64, 250, 4, 0, 0, -512},
      '{0, 0, 1, 2047, -2048, 0},
      '{320, 65535, 15, -2048, 2047, -2048},
      '{511, 20, 0, 100, -100, -512},
      '{32, 100, 2, -1, 1, 2047}
    };
    int unsigned per_phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: at rest, field extremes, timestamp extremes, all during the fill
    dir_rows.push_back('{'{32'h0, 12'sd0, 12'sd0, -12'sd512}, 1'b1});
    dir_rows.push_back('{'{32'hFFFF_FFFF, 12'sd2047, 12'sd2047, 12'sd2047}, 1'b0});
    dir_rows.push_back('{'{32'h1, -12'sd2048, -12'sd2048, -12'sd2048}, 1'b0});
    dir_rows.push_back('{'{32'h2, -12'sd2048, 12'sd0, -12'sd512}, 1'b0});
    dir_rows.push_back('{'{32'h3, 12'sd0, 12'sd2047, -12'sd512}, 1'b0});
    dir_rows.push_back('{'{32'h4, 12'sd0, 12'sd0, -12'sd2048}, 1'b0});
    dir_rows.push_back('{'{32'h5, 12'sd0, 12'sd0, 12'sd2047}, 1'b0});
    dir_rows.push_back('{'{32'h6, 12'sd1, 12'sd0, -12'sd512}, 1'b0});
    dir_rows.push_back('{'{32'h7, -12'sd1, -12'sd1, -12'sd513}, 1'b0});
    dir_rows.push_back('{'{32'h8000_0000, 12'sd0, 12'sd0, -12'sd512}, 1'b1});
    dir_rows.push_back('{'{32'h5555_5555, 12'sd1365, -12'sd1366, 12'sd1365}, 1'b0});
    dir_rows.push_back('{'{32'hAAAA_AAAA, -12'sd1366, 12'sd1365, -12'sd1366}, 1'b0});
    dir_rows.push_back('{'{32'h7FFF_FFFF, 12'sd0, 12'sd0, -12'sd512}, 1'b1});
    dir_rows.push_back('{'{32'h10, 12'sd3, 12'sd4, -12'sd512}, 1'b0});
    dir_rows.push_back('{'{32'h11, 12'sd0, 12'sd0, -12'sd512}, 1'b1});
    foreach (dir_rows[i]) send_sample(dir_rows[i].s, dir_rows[i].typed);

    per_phase = (ITEMS_TOTAL - dir_rows.size()) / 5;
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_reg(REG_SENS, settings[p][0]);
      write_reg(REG_GAP, settings[p][1]);
      write_reg(REG_PEAKS, settings[p][2]);
      write_reg(REG_XB, settings[p][3]);
      write_reg(REG_YB, settings[p][4]);
      write_reg(REG_ZB, settings[p][5]);
      @(posedge clk);
      // last phase runs across the timestamp wrap
      if (p == 4) now_ms = 32'hFFFF_FE00;
      for (int unsigned k = 0; k < per_phase; k++)
        send_sample(make_sample(settings[p][1]), 1'b0);
    end

    wait_idle();
    if (error_count == 0) begin
      $display("adaptive_threshold_hit_counter test passed");
    end else begin
      $display("adaptive_threshold_hit_counter test failed");
    end
    $finish;
  end

endmodule
